// ===== src/tlfua_pkg.sv =====
// ----------------------------------------------------------------------------
// tlfua_pkg
// Shared types and constants of the timed lowest-free unit allocator.
// ----------------------------------------------------------------------------
package tlfua_pkg;

    localparam int POOL_UNITS_DEF = 64;
    localparam int TIME_W         = 20;
    localparam int END_W          = 21;
    localparam int WANT_W         = 7;
    localparam int LEN_W          = 10;
    localparam int SUM_W          = 12;
    localparam int CFG_W          = 7;
    localparam int IN_DATA_W      = 40;
    localparam int OUT_DATA_W     = 16;

    localparam logic [CFG_W-1:0] UNITS_RESET = 7'd64;

    typedef struct packed {
        logic             rejected;
        logic [SUM_W-1:0] index_sum;
    } t_result;

    typedef struct packed {
        logic [TIME_W-1:0] arrival_time;
        logic [WANT_W-1:0] units_wanted;
        logic [LEN_W-1:0]  lease_length;
    } t_request;

endpackage

// ===== src/tlfua_mem.sv =====
// ----------------------------------------------------------------------------
// tlfua_mem
// Lease end store: registered synchronous read, one write port, per-entry
// valid bits so that an entry never written reads as zero (free).
// ----------------------------------------------------------------------------
module tlfua_mem #(
    parameter int POOL_UNITS = tlfua_pkg::POOL_UNITS_DEF,
    parameter int AW         = (POOL_UNITS > 1) ? $clog2(POOL_UNITS) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_rd_en,
    input  logic [AW-1:0]              i_rd_addr,
    output logic [tlfua_pkg::END_W-1:0] o_rd_data,
    input  logic                       i_wr_en,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [tlfua_pkg::END_W-1:0] i_wr_data
);
    import tlfua_pkg::*;

    logic [END_W-1:0]      r_mem [POOL_UNITS];
    logic [POOL_UNITS-1:0] r_vld;
    logic [END_W-1:0]      r_rd_data;
    logic                  r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_hit <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_hit ? r_rd_data : '0;

endmodule

// ===== src/tlfua_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlfua_ctrl
// Request sequencer: a counting pass over the store, then, unless too few units
// are free, an allocating read-modify-write pass that leases the lowest free units.
// ----------------------------------------------------------------------------
module tlfua_ctrl #(
    parameter int POOL_UNITS = tlfua_pkg::POOL_UNITS_DEF,
    parameter int AW         = (POOL_UNITS > 1) ? $clog2(POOL_UNITS) : 1,
    parameter int CW         = $clog2(POOL_UNITS + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [tlfua_pkg::CFG_W-1:0] i_units_in_use,
    input  logic                        i_req_vld,
    output logic                        o_req_rdy,
    input  tlfua_pkg::t_request         i_req,
    output logic                        o_res_vld,
    input  logic                        i_res_rdy,
    output tlfua_pkg::t_result          o_res,
    output logic                        o_rd_en,
    output logic [AW-1:0]               o_rd_addr,
    input  logic [tlfua_pkg::END_W-1:0] i_rd_data,
    output logic                        o_wr_en,
    output logic [AW-1:0]               o_wr_addr,
    output logic [tlfua_pkg::END_W-1:0] o_wr_data
);
    import tlfua_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_COUNT = 4'b0010,
        S_ALLOC = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    localparam logic [CFG_W-1:0] POOL_CFG = CFG_W'(POOL_UNITS);

    t_state             r_state, n_state;
    logic [TIME_W-1:0]  r_now, n_now;
    logic [WANT_W-1:0]  r_want, n_want;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [CW-1:0]      r_lim, n_lim;
    logic [CW-1:0]      r_iss, n_iss;
    logic               r_pend, n_pend;
    logic [AW-1:0]      r_paddr, n_paddr;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [WANT_W-1:0]  r_taken, n_taken;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic               r_rej, n_rej;

    logic               rd_go;
    logic               unit_free;
    logic               take;
    logic [CW-1:0]      lim_cfg;

    assign lim_cfg   = (i_units_in_use > POOL_CFG) ? CW'(POOL_UNITS)
                                                   : i_units_in_use[CW-1:0];
    assign rd_go     = (r_state == S_COUNT || r_state == S_ALLOC) && (r_iss < r_lim);
    assign unit_free = ({1'b0, r_now} >= i_rd_data);
    assign take      = (r_state == S_ALLOC) && r_pend && unit_free && (r_taken < r_want);

    assign o_req_rdy = (r_state == S_IDLE);
    assign o_res_vld = (r_state == S_DONE);
    assign o_res     = '{rejected: r_rej, index_sum: r_sum};
    assign o_rd_en   = rd_go;
    assign o_rd_addr = r_iss[AW-1:0];
    assign o_wr_en   = take;
    assign o_wr_addr = r_paddr;
    assign o_wr_data = END_W'(r_now) + END_W'(r_len);

    always_comb begin
        n_state = r_state;
        n_now   = r_now;
        n_want  = r_want;
        n_len   = r_len;
        n_lim   = r_lim;
        n_iss   = r_iss;
        n_pend  = rd_go;
        n_paddr = r_iss[AW-1:0];
        n_cnt   = r_cnt;
        n_taken = r_taken;
        n_sum   = r_sum;
        n_rej   = r_rej;
        if (rd_go) begin
            n_iss = r_iss + CW'(1);
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_req_vld) begin
                    n_now   = i_req.arrival_time;
                    n_want  = i_req.units_wanted;
                    n_len   = i_req.lease_length;
                    n_lim   = lim_cfg;
                    n_iss   = '0;
                    n_cnt   = '0;
                    n_state = S_COUNT;
                end
            end
            S_COUNT: begin
                if (r_pend && unit_free) begin
                    n_cnt = r_cnt + CW'(1);
                end
                if (!rd_go && !r_pend) begin
                    n_sum   = '0;
                    n_taken = '0;
                    n_iss   = '0;
                    if (8'(r_cnt) < 8'(r_want)) begin
                        n_rej   = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_rej   = 1'b0;
                        n_state = S_ALLOC;
                    end
                end
            end
            S_ALLOC: begin
                if (take) begin
                    n_sum   = r_sum + SUM_W'(r_paddr) + SUM_W'(1);
                    n_taken = r_taken + WANT_W'(1);
                end
                if (!rd_go && !r_pend) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_rdy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now   <= n_now;
        r_want  <= n_want;
        r_len   <= n_len;
        r_lim   <= n_lim;
        r_iss   <= n_iss;
        r_paddr <= n_paddr;
        r_cnt   <= n_cnt;
        r_taken <= n_taken;
        r_sum   <= n_sum;
        r_rej   <= n_rej;
    end

endmodule

// ===== src/timed_lowest_free_unit_allocator.sv =====
// ----------------------------------------------------------------------------
// timed_lowest_free_unit_allocator
// Leases the lowest-numbered free units of a timed pool and returns the sum
// of their 1-based indices, or rejects when too few units are free.
//
//   channel  direction  carries
//   s        in         arrival_time, units_wanted, lease_length
//   m        out        rejected (tuser), index_sum (tdata)
//   cfg      in         units_in_use (write only)
//
// An item takes one read pass over the lease store to count free units
// and, unless it is rejected, one read-modify-write pass to lease them;
// each pass covers units_in_use units, capped at the pool size, and is
// limited by the single read port.
// Reset is synchronous; every unit is free and units_in_use is 64 after it.
// A result waits in the output register while the next item is accepted;
// a held result stalls only the finish of the following item.
// ----------------------------------------------------------------------------
module timed_lowest_free_unit_allocator #(
    parameter int POOL_UNITS = tlfua_pkg::POOL_UNITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // arrival_time[19:0], units_wanted[26:20], lease_length[36:27], zeros
    input  logic [tlfua_pkg::IN_DATA_W-1:0]  i_s_tdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // index_sum[11:0], zeros
    output logic [tlfua_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // rejected[0]
    output logic                             o_m_tuser,
    input  logic                             i_cfg_we,
    input  logic [tlfua_pkg::CFG_W-1:0]      i_cfg_wdata
);
    import tlfua_pkg::*;

    localparam int AW = (POOL_UNITS > 1) ? $clog2(POOL_UNITS) : 1;
    localparam int CW = $clog2(POOL_UNITS + 1);

    logic [CFG_W-1:0] r_units;
    logic             r_out_vld;
    t_result          r_out;
    t_request         req;
    t_result          res;
    logic             res_vld;
    logic             res_rdy;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [END_W-1:0] rd_data;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [END_W-1:0] wr_data;

    assign req.arrival_time = i_s_tdata[19:0];
    assign req.units_wanted = i_s_tdata[26:20];
    assign req.lease_length = i_s_tdata[36:27];

    assign res_rdy    = !r_out_vld || i_m_tready;
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = OUT_DATA_W'(r_out.index_sum);
    assign o_m_tuser  = r_out.rejected;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_units   <= UNITS_RESET;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_units <= i_cfg_wdata;
            end
            if (res_rdy) begin
                r_out_vld <= res_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_rdy && res_vld) begin
            r_out <= res;
        end
    end

    tlfua_ctrl #(
        .POOL_UNITS (POOL_UNITS),
        .AW         (AW),
        .CW         (CW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_units_in_use (r_units),
        .i_req_vld      (i_s_tvalid),
        .o_req_rdy      (o_s_tready),
        .i_req          (req),
        .o_res_vld      (res_vld),
        .i_res_rdy      (res_rdy),
        .o_res          (res),
        .o_rd_en        (rd_en),
        .o_rd_addr      (rd_addr),
        .i_rd_data      (rd_data),
        .o_wr_en        (wr_en),
        .o_wr_addr      (wr_addr),
        .o_wr_data      (wr_data)
    );

    tlfua_mem #(
        .POOL_UNITS (POOL_UNITS),
        .AW         (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

endmodule
